// ===== sv/bts_pkg.sv =====
// Package: shared types and codes for the block transfer sequencer.
`default_nettype none
package bts_pkg;

	localparam int unsigned ListW  = 16;
	localparam int unsigned RegW   = 4;
	localparam int unsigned WordW  = 32;
	localparam int unsigned KindW  = 3;
	localparam int unsigned CountW = 5;
	localparam logic [RegW-1:0] PcReg = 4'hf;
	localparam logic [WordW-1:0] WordStep = 32'h4;
	localparam logic [WordW-1:0] EmptySpan = 32'h40;

	typedef enum logic [KindW-1:0] {
		K_LOAD      = 3'd0,
		K_LOAD_USER = 3'd1,
		K_LOAD_PSR  = 3'd2,
		K_LOAD_JUMP = 3'd3,
		K_STORE     = 3'd4,
		K_STORE_USR = 3'd5,
		K_STORE_VAL = 3'd6,
		K_WRITEBACK = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_XFER,
		ST_WB
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic xfer;
		logic wb;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic wb_needed;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/bts_datapath.sv =====
// Datapath: request registers, address and base arithmetic, result registers.
`default_nettype none
module bts_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bts_pkg::cmd_t              cmd,
	output bts_pkg::status_t                status,
	input  wire logic                       pre_index,
	input  wire logic                       go_up,
	input  wire logic                       psr_or_user,
	input  wire logic                       write_back,
	input  wire logic                       is_load,
	input  wire logic [bts_pkg::RegW-1:0]   base_reg,
	input  wire logic [bts_pkg::ListW-1:0]  reg_list,
	input  wire logic [bts_pkg::WordW-1:0]  base_value,
	input  wire logic [bts_pkg::WordW-1:0]  pc_value,
	output logic                            strobe,
	output logic [bts_pkg::KindW-1:0]       kind,
	output logic [bts_pkg::WordW-1:0]       address,
	output logic [bts_pkg::RegW-1:0]        reg_index,
	output logic [bts_pkg::WordW-1:0]       value,
	output logic                            last
);
	import bts_pkg::*;

	logic             up_q, s_q, wb_q, ld_q, pc_listed_q, first_pend_q, wbn_q;
	logic [RegW-1:0]  rn_q;
	logic [ListW-1:0] list_q;
	logic [WordW-1:0] base_q, base_adj_q, pcst_q, addr_q, newbase_q;

	logic [CountW-1:0] cnt;
	logic [WordW-1:0]  span;
	logic [ListW-1:0]  low_bit;
	logic [RegW-1:0]   idx;
	kind_t             xkind;
	logic [WordW-1:0]  xvalue;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < ListW; i++) begin
			cnt = cnt + CountW'(list_q[i]);
		end
		span = (list_q == '0) ? EmptySpan : {{(WordW-CountW-2){1'b0}}, cnt, 2'b00};
	end

	assign low_bit = list_q & (~list_q + ListW'(1));

	always_comb begin
		idx = '0;
		for (int i = ListW - 1; i >= 0; i--) begin
			if (list_q[i]) begin
				idx = RegW'(i);
			end
		end
	end

	always_comb begin
		xvalue = '0;
		if (ld_q) begin
			if (s_q) begin
				xkind = pc_listed_q ? ((idx == PcReg) ? K_LOAD_PSR : K_LOAD) : K_LOAD_USER;
			end else begin
				xkind = (idx == PcReg) ? K_LOAD_JUMP : K_LOAD;
			end
		end else if (idx == PcReg) begin
			xkind  = K_STORE_VAL;
			xvalue = pcst_q;
		end else if (s_q) begin
			xkind = K_STORE_USR;
		end else if (idx == rn_q && !first_pend_q && wb_q) begin
			xkind  = K_STORE_VAL;
			xvalue = newbase_q;
		end else begin
			xkind = K_STORE;
		end
	end

	assign status.more      = (list_q & ~low_bit) != '0;
	assign status.wb_needed = wbn_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			up_q       <= go_up;
			s_q        <= psr_or_user;
			wb_q       <= write_back;
			ld_q       <= is_load;
			rn_q       <= base_reg;
			list_q     <= reg_list;
			base_q     <= base_value;
			base_adj_q <= (pre_index == go_up) ? base_value + WordStep : base_value;
			pcst_q     <= pc_value + WordStep;
		end
		if (cmd.setup) begin
			addr_q       <= up_q ? base_adj_q : base_adj_q - span;
			newbase_q    <= up_q ? base_q + span : base_q - span;
			pc_listed_q  <= list_q[ListW-1];
			first_pend_q <= 1'b1;
			wbn_q        <= wb_q && !(ld_q && list_q[rn_q]);
			if (list_q == '0) begin
				list_q <= {1'b1, {(ListW-1){1'b0}}};
				s_q    <= 1'b0;
			end
		end
		if (cmd.xfer) begin
			list_q       <= list_q & ~low_bit;
			addr_q       <= addr_q + WordStep;
			first_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.xfer | cmd.wb;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.xfer) begin
			kind      <= xkind;
			address   <= addr_q;
			reg_index <= idx;
			value     <= xvalue;
			last      <= cmd.last;
		end else if (cmd.wb) begin
			kind      <= K_WRITEBACK;
			address   <= '0;
			reg_index <= rn_q;
			value     <= newbase_q;
			last      <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/bts_ctrl.sv =====
// Controller: state machine that sequences setup, transfers and writeback.
`default_nettype none
module bts_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire bts_pkg::status_t   status,
	output bts_pkg::cmd_t           cmd,
	output logic                    busy
);
	import bts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_XFER;
			ST_XFER: begin
				if (!status.more) state_d = status.wb_needed ? ST_WB : ST_IDLE;
			end
			ST_WB: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_XFER: begin
				cmd.xfer = 1'b1;
				cmd.last = !status.more && !status.wb_needed;
			end
			ST_WB: cmd.wb = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/block_transfer_sequencer_top.sv =====
// Top level: block transfer sequencer, controller joined to datapath.
//
// Usage: present one decoded load/store-multiple request on the input ports
// with start high; it is taken at a rising edge where busy is low. Inputs
// are sampled only at that edge.
// The block then emits its bus accesses lowest register first, one per
// cycle, each marked by strobe for exactly one cycle, followed by the base
// writeback result when one applies. last marks the final result.
// After the accepting edge a request passes the setup state, then its first
// result is registered at the outputs. It occupies the block through setup,
// one transfer per listed register (one for an empty list) and a writeback
// step if one is emitted. Setup computes count, start address and new base;
// the transfer state then walks the list one register per cycle.
// The receiver cannot stall; results must be taken when strobe is high.
// Reset clears the controller to idle and drops strobe; no request is held.
`default_nettype none
module block_transfer_sequencer_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       pre_index,
	input  wire logic                       go_up,
	input  wire logic                       psr_or_user,
	input  wire logic                       write_back,
	input  wire logic                       is_load,
	input  wire logic [bts_pkg::RegW-1:0]   base_reg,
	input  wire logic [bts_pkg::ListW-1:0]  reg_list,
	input  wire logic [bts_pkg::WordW-1:0]  base_value,
	input  wire logic [bts_pkg::WordW-1:0]  pc_value,
	output logic                            strobe,
	output logic [bts_pkg::KindW-1:0]       kind,
	output logic [bts_pkg::WordW-1:0]       address,
	output logic [bts_pkg::RegW-1:0]        reg_index,
	output logic [bts_pkg::WordW-1:0]       value,
	output logic                            last
);
	import bts_pkg::*;

	cmd_t    cmd;
	status_t status;

	bts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	bts_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.pre_index   (pre_index),
		.go_up       (go_up),
		.psr_or_user (psr_or_user),
		.write_back  (write_back),
		.is_load     (is_load),
		.base_reg    (base_reg),
		.reg_list    (reg_list),
		.base_value  (base_value),
		.pc_value    (pc_value),
		.strobe      (strobe),
		.kind        (kind),
		.address     (address),
		.reg_index   (reg_index),
		.value       (value),
		.last        (last)
	);

endmodule
`default_nettype wire
